// File: hw/rtl/sha256_byte_stream_hasher_top_assert.svh
// Assertion macros shared by the SHA-256 byte stream hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks a condition at every clock edge outside reset.
`define SBH_ASSERT(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// Checks that a trigger is followed by a condition in the next cycle.
`define SBH_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) else $error(msg);
`else
`define SBH_ASSERT(lbl, clk, rstn, cond, msg)
`define SBH_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg)
`endif
`endif

// File: hw/rtl/sbh_pkg.sv
// Package with the SHA-256 constants, round functions and sequencer types.
package sbh_pkg;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0]  PAD_MARK     = 8'h80;
    localparam logic [4:0]  LEN_WORD_POS = 5'd14;
    localparam logic [4:0]  BLOCK_WORDS  = 5'd16;
    localparam logic [5:0]  LAST_ROUND   = 6'd63;
    localparam logic [5:0]  LAST_FILL    = 6'd63;
    localparam logic [2:0]  LAST_INDEX   = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_HADD,
        ST_PAD_FIRST,
        ST_PAD_FILL,
        ST_PAD_LEN,
        ST_OUT
    } sbh_state_t;

    // Where the sequencer goes once a compression has been added in.
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_FILL,
        RET_DIGEST
    } sbh_ret_t;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// File: hw/rtl/sha256_byte_stream_hasher_top.sv
// Top level of the SHA-256 byte stream hasher: byte packing, padding and round unit.
//
// This block hashes one message at a time with SHA-256. Message bytes come in as
// items on the slave stream, one byte per item, and are packed big-endian into a
// 16-word message window. While a block fills, one item is taken every cycle; the
// 64th byte of a block starts the compression, and the block then holds s_tready low
// while it loads the working variables, runs the rounds through the single round
// unit and adds the result into the hash state. An item with tlast set ends the
// message after its byte (an item with the byte flag clear carries no byte). Padding
// then shifts one word per cycle into the window outside a compression (the 0x80
// marker word, zero words and the two words of the 64-bit bit length), using a
// second compression when more than 55 bytes are pending in the last block; the end
// of a message takes one or two compressions. The eight digest words then leave on
// the master stream, word 0 first, with tlast on word 7; no input is taken until the
// last word has been accepted, and the hash state, byte count and fill return to
// their start values for the next message. The round unit is the only place where
// the work is done.
module sha256_byte_stream_hasher_top
    import sbh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

`include "sha256_byte_stream_hasher_top_assert.svh"

    sbh_state_t  state_reg, state_next;
    sbh_ret_t    ret_reg;

    logic [31:0] hash_reg [8];
    logic [31:0] v_reg    [8];
    // Message window as a shift line: word 0 of the block sits in win_reg[0].
    logic [31:0] win_reg  [16];
    logic [23:0] acc_reg;
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic [5:0]  round_reg;
    logic [4:0]  wcnt_reg;
    logic [2:0]  out_idx_reg;

    logic        in_accept;
    logic        out_accept;
    logic        win_shift;
    logic [31:0] win_in;
    logic [31:0] pad_word;
    logic [31:0] sched_word;
    logic [31:0] t1;
    logic [31:0] t2;

    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;

    // Pending bytes followed by the marker byte, left aligned in the word.
    assign pad_word = {acc_reg, PAD_MARK} << {2'd3 - fill_reg[1:0], 3'b000};

    // Round unit: schedule extension and the compression round run in the same cycle.
    assign sched_word = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign t1 = v_reg[7] + bsig1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
              + ROUND_K[round_reg] + win_reg[0];
    assign t2 = bsig0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser[0] && fill_reg == LAST_FILL) begin
                        state_next = ST_LOAD;
                    end else if (s_tlast) begin
                        state_next = ST_PAD_FIRST;
                    end
                end
            end
            ST_LOAD:      state_next = ST_ROUND;
            ST_ROUND: begin
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_HADD;
                end
            end
            ST_HADD: begin
                case (ret_reg)
                    RET_IDLE:   state_next = ST_IDLE;
                    RET_PAD:    state_next = ST_PAD_FIRST;
                    RET_FILL:   state_next = ST_PAD_FILL;
                    RET_DIGEST: state_next = ST_OUT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_PAD_FIRST: state_next = ST_PAD_FILL;
            ST_PAD_FILL: begin
                if (wcnt_reg == LEN_WORD_POS) begin
                    state_next = ST_PAD_LEN;
                end else if (wcnt_reg == BLOCK_WORDS) begin
                    state_next = ST_LOAD;
                end
            end
            ST_PAD_LEN:   state_next = ST_LOAD;
            ST_OUT: begin
                if (out_accept && out_idx_reg == LAST_INDEX) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs and the word shifted into the window.
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = (state_reg == ST_OUT);
        m_tdata   = hash_reg[out_idx_reg];
        m_tuser   = out_idx_reg;
        m_tlast   = (out_idx_reg == LAST_INDEX);
        win_shift = 1'b0;
        win_in    = 32'd0;
        case (state_reg)
            ST_IDLE: begin
                win_shift = in_accept && s_tuser[0] && (fill_reg[1:0] == 2'd3);
                win_in    = {acc_reg, s_tdata};
            end
            ST_ROUND: begin
                win_shift = 1'b1;
                win_in    = sched_word;
            end
            ST_PAD_FIRST: begin
                win_shift = 1'b1;
                win_in    = pad_word;
            end
            ST_PAD_FILL: begin
                win_shift = (wcnt_reg != BLOCK_WORDS);
                win_in    = (wcnt_reg == LEN_WORD_POS) ? count_reg[60:29] : 32'd0;
            end
            ST_PAD_LEN: begin
                win_shift = 1'b1;
                win_in    = {count_reg[28:0], 3'b000};
            end
            default: begin
                win_shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (win_shift) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= win_in;
        end
    end

    // Working variables and the digest state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= INIT_HASH[i];
            end
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    for (int i = 0; i < 8; i++) begin
                        v_reg[i] <= hash_reg[i];
                    end
                end
                ST_ROUND: begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                ST_HADD: begin
                    for (int i = 0; i < 8; i++) begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                end
                ST_OUT: begin
                    if (out_accept && out_idx_reg == LAST_INDEX) begin
                        for (int i = 0; i < 8; i++) begin
                            hash_reg[i] <= INIT_HASH[i];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Byte packing, counters and the sequencer's return target.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ret_reg     <= RET_IDLE;
            fill_reg    <= 6'd0;
            count_reg   <= 61'd0;
            round_reg   <= 6'd0;
            wcnt_reg    <= 5'd0;
            out_idx_reg <= 3'd0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept && s_tuser[0]) begin
                        acc_reg   <= {acc_reg[15:0], s_tdata};
                        fill_reg  <= fill_reg + 6'd1;
                        count_reg <= count_reg + 61'd1;
                        ret_reg   <= s_tlast ? RET_PAD : RET_IDLE;
                    end
                end
                ST_LOAD: begin
                    round_reg <= 6'd0;
                end
                ST_ROUND: begin
                    round_reg <= round_reg + 6'd1;
                end
                ST_PAD_FIRST: begin
                    wcnt_reg <= {1'b0, fill_reg[5:2]} + 5'd1;
                end
                ST_PAD_FILL: begin
                    if (wcnt_reg == BLOCK_WORDS) begin
                        wcnt_reg <= 5'd0;
                        ret_reg  <= RET_FILL;
                    end else begin
                        wcnt_reg <= wcnt_reg + 5'd1;
                    end
                end
                ST_PAD_LEN: begin
                    ret_reg <= RET_DIGEST;
                end
                ST_OUT: begin
                    if (out_accept) begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == LAST_INDEX) begin
                            fill_reg  <= 6'd0;
                            count_reg <= 61'd0;
                            wcnt_reg  <= 5'd0;
                            ret_reg   <= RET_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `SBH_ASSERT(a_one_side_open, aclk, aresetn, !(s_tready && m_tvalid),
                "both stream sides open")
    `SBH_ASSERT(a_round_idle, aclk, aresetn,
                (state_reg == ST_ROUND) || (round_reg == 6'd0),
                "round counter left running")
    `SBH_ASSERT(a_wcnt_range, aclk, aresetn, wcnt_reg <= BLOCK_WORDS,
                "padding word count beyond a block")
    `SBH_ASSERT_NEXT(a_restart, aclk, aresetn, out_accept && m_tlast,
                     s_tready && (count_reg == 61'd0) && (fill_reg == 6'd0),
                     "no fresh start after digest")
    `SBH_ASSERT_NEXT(a_block_full, aclk, aresetn,
                     in_accept && s_tuser[0] && (fill_reg == LAST_FILL),
                     !s_tready && (fill_reg == 6'd0),
                     "full block not compressed")

endmodule

// File: test/sha256_byte_stream_hasher_top_test.sv
// Self-checking testbench for the SHA-256 byte stream hasher, with its own digest predictor.
module sha256_byte_stream_hasher_top_test;

    localparam int ITEM_TARGET = 410;
    localparam int LONG_STALL  = 400;
    localparam int MAX_SHOWN   = 10;
    localparam int SETTLE      = 100;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] SHA_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // One input item, plus a flag that makes the sender wait for an idle block first.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eom;
        logic       wait_idle;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    sha256_byte_stream_hasher_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    byte_item_t   pending_bytes [$];
    digest_word_t digest_words [$];

    // Predictor state: chaining value, the block being filled, and the message length.
    logic [31:0] chain_h [0:7];
    logic [7:0]  msg_bytes [0:63];
    logic [60:0] byte_total;
    logic [5:0]  fill_bytes;

    int items_total    = 0;
    int items_taken    = 0;
    int words_checked  = 0;
    int fail_count     = 0;
    int msg_count      = 0;
    int ignored_count  = 0;
    int longest_msg    = 0;
    logic s_taken      = 1'b0;

    int gap_left       = 0;
    int burst_left     = 1;
    int stall_left     = 0;
    int phase_left     = 1;
    int ready_mode     = 0;
    bit long_stall_done = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] rot_r(logic [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int j = 0; j < 8; j++) chain_h[j] = SHA_IV[j];
        byte_total = '0;
        fill_bytes = '0;
    endfunction

    // Runs the 64 rounds over msg_bytes and adds the result into the chaining value.
    function automatic void fold_block();
        logic [31:0] sched [0:63];
        logic [31:0] v [0:7];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            sched[i] = {msg_bytes[4*i], msg_bytes[4*i+1], msg_bytes[4*i+2], msg_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            sched[i] = (rot_r(sched[i-2], 17) ^ rot_r(sched[i-2], 19) ^ (sched[i-2] >> 10))
                     + sched[i-7]
                     + (rot_r(sched[i-15], 7) ^ rot_r(sched[i-15], 18) ^ (sched[i-15] >> 3))
                     + sched[i-16];
        for (int j = 0; j < 8; j++) v[j] = chain_h[j];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rot_r(v[4], 6) ^ rot_r(v[4], 11) ^ rot_r(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + sched[i];
            t2 = (rot_r(v[0], 2) ^ rot_r(v[0], 13) ^ rot_r(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) chain_h[j] = chain_h[j] + v[j];
    endfunction

    // Absorbs one accepted item; at end of message pads, finishes and queues the digest.
    function automatic void absorb_item(logic [7:0] data, logic present, logic eom);
        logic [63:0] bit_len;
        if (present) begin
            msg_bytes[fill_bytes] = data;
            byte_total = byte_total + 1'b1;
            fill_bytes = fill_bytes + 1'b1;
            if (fill_bytes == 0) fold_block();
        end
        if (!eom) return;
        msg_bytes[fill_bytes] = PAD_BYTE;
        for (int i = fill_bytes + 1; i < 64; i++) msg_bytes[i] = 8'h00;
        // No room for the length field: finish this block and pad a fresh one.
        if (fill_bytes > 55) begin
            fold_block();
            for (int i = 0; i < 56; i++) msg_bytes[i] = 8'h00;
        end
        bit_len = {byte_total, 3'b000};
        for (int i = 0; i < 8; i++) msg_bytes[56 + i] = bit_len[63 - 8*i -: 8];
        fold_block();
        for (int j = 0; j < 8; j++)
            digest_words.push_back('{word: chain_h[j], index: j[2:0], last: (j == 7)});
        restart_hash();
    endfunction

    function automatic void push_item(logic [7:0] data, logic present, logic eom,
                                      logic wait_idle);
        pending_bytes.push_back('{data: data, present: present, eom: eom,
                                  wait_idle: wait_idle});
        if (eom) msg_count++;
        if (!present && !eom) ignored_count++;
    endfunction

    // Queues a message of random bytes, with an occasional ignored item in between.
    function automatic void queue_message(int len, bit end_alone, bit wait_idle);
        bit hold = wait_idle;
        if (len == 0) end_alone = 1'b1;
        if (len > longest_msg) longest_msg = len;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, hold);
                hold = 1'b0;
            end
            push_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_alone, hold);
            hold = 1'b0;
        end
        if (end_alone) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, hold);
    endfunction

    function automatic int pick_length();
        int edges [10] = '{0, 1, 54, 55, 56, 57, 62, 63, 64, 65};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 12);
            4, 5, 6:    return edges[$urandom_range(0, 9)];
            default:    return $urandom_range(13, 100);
        endcase
    endfunction

    // Remembers whether the item on the input was taken at the last rising edge.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_tvalid && s_tready;
    end

    // Sender: bursts of items with random gaps. An item marked wait_idle is held back
    // until every outstanding digest word has been received.
    always @(negedge aclk) begin
        byte_item_t head;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0 &&
                         !(pending_bytes[0].wait_idle && digest_words.size() != 0)) begin
                head = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= head.data;
                s_tuser  <= head.present;
                s_tlast  <= head.eom;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready pattern changes by phase; once, after two digests, it holds off
    // for a long stretch so the block backs up and stops taking input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!long_stall_done && words_checked >= 16) begin
            long_stall_done = 1'b1;
            stall_left = LONG_STALL - 1;
            m_tready <= 1'b0;
        end else begin
            if (phase_left > 1) begin
                phase_left--;
            end else begin
                phase_left = $urandom_range(8, 80);
                ready_mode = $urandom_range(0, 3);
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Monitor: predicts on every accepted input item and checks every accepted word.
    always @(posedge aclk) begin
        digest_word_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                absorb_item(s_tdata, s_tuser[0], s_tlast);
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (digest_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("ERROR: unexpected digest word %h index %0d last %b",
                                 m_tdata, m_tuser, m_tlast);
                end else begin
                    want = digest_words.pop_front();
                    words_checked++;
                    if (m_tdata !== want.word || m_tuser !== want.index ||
                        m_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN)
                            $display("ERROR: want %h idx %0d last %b, got %h idx %0d last %b",
                                     want.word, want.index, want.last,
                                     m_tdata, m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    initial begin
        int len;
        restart_hash();
        for (int i = 0; i < 64; i++) msg_bytes[i] = 8'h00;

        // Directed: empty message, byte and end in one item, end on its own item,
        // byte extremes, ignored items, and an empty message after a digest.
        push_item(8'h00, 1'b0, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0, 1'b0);
        push_item(8'hff, 1'b0, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b1, 1'b0);
        push_item(8'h5a, 1'b0, 1'b1, 1'b1);
        longest_msg = 3;

        // Lengths around the padding boundaries, then random messages; the last
        // message is cut short so the item count lands near the target.
        queue_message(55, ($urandom_range(0, 1) == 1), 1'b1);
        queue_message(56, ($urandom_range(0, 1) == 1), 1'b0);
        queue_message(63, ($urandom_range(0, 1) == 1), 1'b0);
        queue_message(64, ($urandom_range(0, 1) == 1), 1'b0);
        while (pending_bytes.size() < ITEM_TARGET) begin
            len = pick_length();
            if (len > ITEM_TARGET - pending_bytes.size())
                len = ITEM_TARGET - pending_bytes.size();
            queue_message(len, $urandom_range(0, 2) == 0,
                          $urandom_range(0, 5) == 0);
        end
        items_total = pending_bytes.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (items_taken < items_total || digest_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Hashed %0d messages of 0 to %0d bytes from %0d items (%0d ignored).",
                 msg_count, longest_msg, items_total, ignored_count);
        $display("Checked %0d digest words across padding edges and a %0d-cycle output hold.",
                 words_checked, LONG_STALL);
        if (fail_count == 0 && digest_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
